// File: sv/assert_macros.svh
// Assertion macros used by the checker file of the converter.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: sv/yuv2i420_pkg.sv
// Shared types and constants of the YUYV 4:2:2 to I420 converter.
// No dependencies; used by the output interface, the line store, the top level and the checker.
package yuv2i420_pkg;

    // Configuration port
    localparam int CFG_W     = 12;
    localparam int REG_IDX_W = 1;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_idx_t;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

    // Result payload
    localparam int LUMA_POS_W   = 22;
    localparam int CHROMA_POS_W = 20;

    typedef enum logic [1:0] {
        PLANE_Y = 2'd0,
        PLANE_U = 2'd1,
        PLANE_V = 2'd2
    } plane_t;

    localparam logic [1:0] BYTES_LUMA   = 2'd2;
    localparam logic [1:0] BYTES_CHROMA = 2'd1;
    localparam logic [LUMA_POS_W-1:0] LUMA_STEP = 22'd2;

    // One line store entry: U in the high byte, V in the low byte
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] red;
    } chroma_pair_t;

    // Truncating average of two bytes
    function automatic logic [7:0] avg8(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[8:1];
    endfunction

endpackage

// File: sv/yuv2i420_pix_if.sv
// Input channel: one packed YUYV group per item, valid/ready handshake.
// Depends on nothing.
interface yuv2i420_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] luma_a;
    logic [7:0] chroma_blue;
    logic [7:0] luma_b;
    logic [7:0] chroma_red;

    modport source (output valid, luma_a, chroma_blue, luma_b, chroma_red, input ready);
    modport sink   (input valid, luma_a, chroma_blue, luma_b, chroma_red, output ready);
endinterface

// File: sv/yuv2i420_wr_if.sv
// Output channel: one plane write per item, valid/ready handshake.
// Depends on yuv2i420_pkg.
interface yuv2i420_wr_if;
    logic                                   valid;
    logic                                   ready;
    yuv2i420_pkg::plane_t                   plane;
    logic [yuv2i420_pkg::LUMA_POS_W-1:0]    offset;
    logic [7:0]                             byte_first;
    logic [7:0]                             byte_second;
    logic [1:0]                             byte_count;
    logic                                   last;

    modport source (output valid, plane, offset, byte_first, byte_second, byte_count, last,
                    input ready);
    modport sink   (input valid, plane, offset, byte_first, byte_second, byte_count, last,
                    output ready);
endinterface

// File: sv/yuv2i420_line_store.sv
// Chroma line store: one write port, one read port with registered read data.
// Depends on yuv2i420_pkg.
module yuv2i420_line_store #(
    parameter int DEPTH = 1024
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic                       rd_en,
    input  logic [$clog2(DEPTH)-1:0]   addr,
    input  yuv2i420_pkg::chroma_pair_t wr_data,
    output yuv2i420_pkg::chroma_pair_t rd_data
);
    import yuv2i420_pkg::*;

    chroma_pair_t mem [DEPTH];
    chroma_pair_t rd_data_reg;

    // Even rows write the pair of the column
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
    end

    // Odd rows read the pair stored by the row above
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/yuyv422_to_i420_converter_unit.sv
// YUYV 4:2:2 packed to I420 planar converter, top level.
// Depends on yuv2i420_pkg, yuv2i420_pix_if, yuv2i420_wr_if, yuv2i420_line_store.
//
// Each input item is one packed group (Y0, U, Y1, V); groups arrive in raster
// order. Every group gives one luma write of two bytes; on odd rows it also gives
// a U and a V write, each the truncated average with the pair stored by the row
// above. Each write leaves through the single result register, one per cycle
// unless stalled; a new group is accepted as the current one's last write is
// loaded. The line store is a memory of MAX_WIDTH/2 entries, written on even
// rows and read on odd rows at accept; it has no clearing pass, so the first
// row after reset must be even and a row may not be wider than the even row
// above it. Frame geometry must be written through the configuration port
// while the block is idle, which it does not enforce; a shrink that leaves the
// position out of range ends the row or frame on the next item.
module yuyv422_to_i420_converter_unit #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [yuv2i420_pkg::REG_IDX_W-1:0]    cfg_index,
    input  logic [yuv2i420_pkg::CFG_W-1:0]        cfg_data,
    yuv2i420_pix_if.sink                          pixels,
    yuv2i420_wr_if.source                         planes
);
    import yuv2i420_pkg::*;

    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int CW = $clog2(LINE_DEPTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int DW = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
    localparam int HW = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;
    localparam logic [DW-1:0] MAX_W_V = DW'(MAX_WIDTH);
    localparam logic [HW-1:0] MAX_H_V = HW'(MAX_HEIGHT);
    localparam logic [DW-1:0] MIN_W_V = DW'(2);
    localparam logic [HW-1:0] MIN_H_V = HW'(2);

    // Configuration registers
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    // Raster position
    logic [CW-1:0]           col_reg,  col_next;
    logic [RW-1:0]           row_reg,  row_next;
    logic [LUMA_POS_W-1:0]   lpos_reg, lpos_next;
    logic [CHROMA_POS_W-1:0] cpos_reg, cpos_next;

    // Geometry and position arithmetic
    logic [DW-1:0]           eff_w;
    logic [DW-1:0]           groups;
    logic [HW-1:0]           eff_h;
    logic [DW-1:0]           c0, c1;
    logic [HW-1:0]           r0, r1;
    logic [LUMA_POS_W-1:0]   lp0;
    logic [CHROMA_POS_W-1:0] cp0;
    logic                    odd_row;

    // Work stage: the item whose results are being issued
    logic                    a_valid_reg, a_valid_next;
    logic                    a_odd_reg;
    logic [7:0]              a_luma_a_reg, a_luma_b_reg, a_blue_reg, a_red_reg;
    logic [LUMA_POS_W-1:0]   a_lpos_reg;
    logic [CHROMA_POS_W-1:0] a_cpos_reg;
    plane_t                  phase_reg, phase_next;

    // Result register
    logic                    out_valid_reg, out_valid_next;
    plane_t                  out_plane_reg;
    logic [LUMA_POS_W-1:0]   out_offset_reg;
    logic [7:0]              out_first_reg, out_second_reg;
    logic [1:0]              out_count_reg;
    logic                    out_last_reg;

    logic                    in_accept;
    logic                    out_load;
    logic                    res_last;
    logic                    a_done;
    chroma_pair_t            above;
    chroma_pair_t            wr_pair;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Effective geometry: bit 0 cleared, clamped to [2, MAX]
    always_comb
    begin
        eff_w = DW'({width_reg[CFG_W-1:1], 1'b0});
        if (eff_w < MIN_W_V)
        begin
            eff_w = MIN_W_V;
        end
        if (eff_w > MAX_W_V)
        begin
            eff_w = MAX_W_V;
        end
        groups = eff_w >> 1;

        eff_h = HW'({height_reg[CFG_W-1:1], 1'b0});
        if (eff_h < MIN_H_V)
        begin
            eff_h = MIN_H_V;
        end
        if (eff_h > MAX_H_V)
        begin
            eff_h = MAX_H_V;
        end
    end

    // Position of this item and of the next one
    always_comb
    begin
        r0  = HW'(row_reg);
        c0  = DW'(col_reg);
        lp0 = lpos_reg;
        cp0 = cpos_reg;
        // row beyond a shrunken height: restart the frame
        if (r0 >= eff_h)
        begin
            r0  = '0;
            c0  = '0;
            lp0 = '0;
            cp0 = '0;
        end
        // column beyond a shrunken width: end the row first
        if (c0 >= groups)
        begin
            c0 = '0;
            r0 = r0 + HW'(1);
            if (r0 >= eff_h)
            begin
                r0  = '0;
                lp0 = '0;
                cp0 = '0;
            end
        end
        odd_row = r0[0];

        lpos_next = lp0 + LUMA_STEP;
        cpos_next = odd_row ? cp0 + CHROMA_POS_W'(1) : cp0;
        c1 = c0 + DW'(1);
        r1 = r0;
        if (c1 >= groups)
        begin
            c1 = '0;
            r1 = r0 + HW'(1);
            if (r1 >= eff_h)
            begin
                r1        = '0;
                lpos_next = '0;
                cpos_next = '0;
            end
        end
        col_next = c1[CW-1:0];
        row_next = r1[RW-1:0];
    end

    // Handshake control
    always_comb
    begin
        out_load  = a_valid_reg && (!out_valid_reg || planes.ready);
        res_last  = (phase_reg == PLANE_V) || (phase_reg == PLANE_Y && !a_odd_reg);
        a_done    = out_load && res_last;
        in_accept = pixels.valid && pixels.ready;

        a_valid_next = in_accept ? 1'b1 : (a_done ? 1'b0 : a_valid_reg);

        phase_next = phase_reg;
        if (out_load)
        begin
            case (phase_reg)
                PLANE_Y: phase_next = a_odd_reg ? PLANE_U : PLANE_Y;
                PLANE_U: phase_next = PLANE_V;
                default: phase_next = PLANE_Y;
            endcase
        end

        out_valid_next = out_load ? 1'b1 : (planes.ready ? 1'b0 : out_valid_reg);
    end

    assign pixels.ready = !a_valid_reg || a_done;

    // Line store: write on even rows, read on odd rows, both at accept.
    // A read of a column always follows its write by at least one item, so
    // no forwarding is needed.
    assign wr_pair.blue = pixels.chroma_blue;
    assign wr_pair.red  = pixels.chroma_red;

    yuv2i420_line_store #(
        .DEPTH (LINE_DEPTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (in_accept && !odd_row),
        .rd_en   (in_accept && odd_row),
        .addr    (c0[CW-1:0]),
        .wr_data (wr_pair),
        .rd_data (above)
    );

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            lpos_reg      <= '0;
            cpos_reg      <= '0;
            a_valid_reg   <= 1'b0;
            phase_reg     <= PLANE_Y;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                col_reg  <= col_next;
                row_reg  <= row_next;
                lpos_reg <= lpos_next;
                cpos_reg <= cpos_next;
            end
            a_valid_reg   <= a_valid_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Work stage payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            a_odd_reg    <= odd_row;
            a_luma_a_reg <= pixels.luma_a;
            a_luma_b_reg <= pixels.luma_b;
            a_blue_reg   <= pixels.chroma_blue;
            a_red_reg    <= pixels.chroma_red;
            a_lpos_reg   <= lp0;
            a_cpos_reg   <= cp0;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_plane_reg <= phase_reg;
            out_last_reg  <= res_last;
            case (phase_reg)
                PLANE_Y:
                begin
                    out_offset_reg <= a_lpos_reg;
                    out_first_reg  <= a_luma_a_reg;
                    out_second_reg <= a_luma_b_reg;
                    out_count_reg  <= BYTES_LUMA;
                end
                PLANE_U:
                begin
                    out_offset_reg <= LUMA_POS_W'(a_cpos_reg);
                    out_first_reg  <= avg8(above.blue, a_blue_reg);
                    out_second_reg <= 8'd0;
                    out_count_reg  <= BYTES_CHROMA;
                end
                default:
                begin
                    out_offset_reg <= LUMA_POS_W'(a_cpos_reg);
                    out_first_reg  <= avg8(above.red, a_red_reg);
                    out_second_reg <= 8'd0;
                    out_count_reg  <= BYTES_CHROMA;
                end
            endcase
        end
    end

    assign planes.valid       = out_valid_reg;
    assign planes.plane       = out_plane_reg;
    assign planes.offset      = out_offset_reg;
    assign planes.byte_first  = out_first_reg;
    assign planes.byte_second = out_second_reg;
    assign planes.byte_count  = out_count_reg;
    assign planes.last        = out_last_reg;

endmodule

// File: sv/yuv2i420_checker.sv
// Port-level checker for the converter top level, attached by bind.
// Depends on yuv2i420_pkg and assert_macros.svh.
`include "assert_macros.svh"

module yuv2i420_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input yuv2i420_pkg::plane_t                 out_plane,
    input logic [yuv2i420_pkg::LUMA_POS_W-1:0]  out_offset,
    input logic                                 out_last
);
    import yuv2i420_pkg::*;

    logic out_take;

    assign out_take = out_valid && out_ready;

    // A stalled result keeps its target
    `ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_offset) && $stable(out_plane))

    // A luma write that does not end its item is followed at once by its U write
    `ASSERT_NEXT(a_luma_then_u, clk, rst_n, out_take && out_plane == PLANE_Y && !out_last, out_valid && out_plane == PLANE_U)

    // The U write is followed at once by the V write at the same offset
    `ASSERT_NEXT(a_u_then_v, clk, rst_n, out_take && out_plane == PLANE_U, out_valid && out_plane == PLANE_V && out_last && out_offset == $past(out_offset))

endmodule

bind yuyv422_to_i420_converter_unit yuv2i420_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (planes.valid),
    .out_ready  (planes.ready),
    .out_plane  (planes.plane),
    .out_offset (planes.offset),
    .out_last   (planes.last)
);
